>>> rtl/circular_array_deque_core_defines.svh
// ----------------------------------------------------------------------------
// circular_array_deque_core_defines.svh
// Assertion macros used by the deque core. Each macro expects clk and rst_n
// in scope.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_ARRAY_DEQUE_CORE_DEFINES_SVH
`define CIRCULAR_ARRAY_DEQUE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define CAD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CAD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cad_pkg.sv
// ----------------------------------------------------------------------------
// cad_pkg
// Types and constants shared by the deque cells, chains and top level.
// ----------------------------------------------------------------------------
package cad_pkg;

  localparam int WORD_W   = 32;
  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 2;

  typedef logic [WORD_W-1:0] cad_word_t;

  // Request codes; unused codes behave as peek
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_REAR  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_REAR   = 3'd3;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } cad_status_t;

  // End word reported for an empty queue
  localparam cad_word_t EMPTY_WORD = '1;

  // Per-cell update select
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_FROM_LEFT  = 2'd1,
    CELL_FROM_RIGHT = 2'd2,
    CELL_LOAD       = 2'd3
  } cad_cell_op_t;

  // Per-chain operation: push shifts in at cell 0, pop shifts toward cell 0,
  // append writes the cell just past the last occupied one
  typedef enum logic [1:0] {
    CHAIN_HOLD   = 2'd0,
    CHAIN_PUSH   = 2'd1,
    CHAIN_POP    = 2'd2,
    CHAIN_APPEND = 2'd3
  } cad_chain_op_t;

  // Operations for both chains, issued by the top level each cycle
  typedef struct packed {
    cad_chain_op_t front;
    cad_chain_op_t rear;
  } cad_ctrl_t;

endpackage

>>> rtl/cad_in_if.sv
// ----------------------------------------------------------------------------
// cad_in_if
// Request channel: valid/ready handshake carrying the request code and word.
// ----------------------------------------------------------------------------
interface cad_in_if import cad_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [WORD_W-1:0] data_value;

  modport source (output valid, output func, output data_value, input ready);
  modport sink   (input valid, input func, input data_value, output ready);
endinterface

>>> rtl/cad_out_if.sv
// ----------------------------------------------------------------------------
// cad_out_if
// Result channel: valid/ready handshake carrying status, end words and flags.
// ----------------------------------------------------------------------------
interface cad_out_if import cad_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [WORD_W-1:0] first_value;
  logic signed [WORD_W-1:0] last_value;
  logic                     is_empty;
  logic                     is_full;

  modport source (output valid, output status, output first_value, output last_value,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input first_value, input last_value,
                  input is_empty, input is_full, output ready);
endinterface

>>> rtl/circular_array_deque_core.sv
// The result of a transferred request is in the output register on the next cycle.
// Throughput: one request per cycle; a request is taken whenever the output register is
// empty or its result is transferred in the same cycle.
// Every cell of both chains updates on the clock edge that takes the request, which sets the rate.
// Reset: synchronous, active low; clears the fill count and output valid (queue empty).
// ----------------------------------------------------------------------------
// circular_array_deque_core
// Double-ended queue of up to DEPTH-1 words. Two cell chains hold the same
// words, one ordered from the front and one from the rear, so both end words
// always sit in cell 0 of a chain.
// ----------------------------------------------------------------------------
`include "circular_array_deque_core_defines.svh"

module circular_array_deque_core import cad_pkg::*; #(
  parameter int unsigned DEPTH = 8
) (
  input  logic   clk,
  input  logic   rst_n,
  cad_in_if.sink    in_chan,
  cad_out_if.source out_chan
);

  localparam int unsigned CELLS = DEPTH - 1;
  localparam int unsigned CNT_W = $clog2(DEPTH);

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_valid_r;
  cad_status_t       out_status_r;
  cad_word_t         out_first_r;
  cad_word_t         out_last_r;
  logic              out_empty_r;
  logic              out_full_r;

  logic              in_ready;
  logic              accept;
  logic [FUNC_W-1:0] func;
  cad_word_t         data_word;
  logic              full;
  logic              empty;
  cad_status_t       status;
  cad_ctrl_t         ctrl;
  cad_word_t         front_head_nxt;
  cad_word_t         rear_head_nxt;

  assign in_ready  = !out_valid_r || out_chan.ready;
  assign accept    = in_chan.valid && in_ready;
  assign func      = in_chan.func;
  assign data_word = cad_word_t'(in_chan.data_value);
  assign full      = (count_r == CNT_W'(CELLS));
  assign empty     = (count_r == '0);

  // Decode the request into chain operations and the next fill count
  always_comb begin
    status     = ST_DONE;
    ctrl.front = CHAIN_HOLD;
    ctrl.rear  = CHAIN_HOLD;
    count_nxt  = count_r;
    if (accept) begin
      unique case (func)
        FN_PUSH_FRONT: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            ctrl.front = CHAIN_PUSH;
            ctrl.rear  = CHAIN_APPEND;
            count_nxt  = count_r + CNT_W'(1);
          end
        end
        FN_PUSH_REAR: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            ctrl.front = CHAIN_APPEND;
            ctrl.rear  = CHAIN_PUSH;
            count_nxt  = count_r + CNT_W'(1);
          end
        end
        FN_POP_FRONT: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            ctrl.front = CHAIN_POP;
            count_nxt  = count_r - CNT_W'(1);
          end
        end
        FN_POP_REAR: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            ctrl.rear = CHAIN_POP;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        default: begin
          status = ST_DONE;
        end
      endcase
    end
  end

  // Chain ordered from the front word
  cad_chain #(
    .CELLS (CELLS),
    .CNT_W (CNT_W)
  ) u_front_chain (
    .clk       (clk),
    .op        (ctrl.front),
    .count     (count_r),
    .push_word (data_word),
    .head_nxt  (front_head_nxt)
  );

  // Chain ordered from the rear word
  cad_chain #(
    .CELLS (CELLS),
    .CNT_W (CNT_W)
  ) u_rear_chain (
    .clk       (clk),
    .op        (ctrl.rear),
    .count     (count_r),
    .push_word (data_word),
    .head_nxt  (rear_head_nxt)
  );

  // Advance the fill count and the output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the result of a transferred request
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status;
      out_first_r  <= (count_nxt == '0) ? EMPTY_WORD : front_head_nxt;
      out_last_r   <= (count_nxt == '0) ? EMPTY_WORD : rear_head_nxt;
      out_empty_r  <= (count_nxt == '0);
      out_full_r   <= (count_nxt == CNT_W'(CELLS));
    end
  end

  assign in_chan.ready        = in_ready;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.first_value = out_first_r;
  assign out_chan.last_value  = out_last_r;
  assign out_chan.is_empty    = out_empty_r;
  assign out_chan.is_full     = out_full_r;

  // Checks
  `CAD_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(CELLS), "fill count beyond capacity")
  `CAD_ASSERT_NEXT(a_push_grows,
    accept && (func == FN_PUSH_FRONT || func == FN_PUSH_REAR) && !full,
    count_r == $past(count_r) + CNT_W'(1), "push did not grow the queue")
  `CAD_ASSERT_NEXT(a_pop_refused,
    accept && (func == FN_POP_FRONT || func == FN_POP_REAR) && empty,
    count_r == '0 && out_status_r == ST_EMPTY && out_empty_r, "refused pop misreported")
  `CAD_ASSERT_IMP(a_stall_blocks, out_valid_r && !out_chan.ready, !in_ready,
    "request taken while result stalled")

endmodule

>>> rtl/cad_cell.sv
// ----------------------------------------------------------------------------
// cad_cell
// One storage cell of a deque chain: holds a word, takes it from a neighbor
// or loads the request word.
// ----------------------------------------------------------------------------
module cad_cell import cad_pkg::*; (
  input  logic         clk,
  input  cad_cell_op_t op,
  input  cad_word_t    left_word,
  input  cad_word_t    right_word,
  input  cad_word_t    load_word,
  output cad_word_t    cur_word,
  output cad_word_t    nxt_word
);

  cad_word_t word_r;
  cad_word_t word_nxt;

  // Select the next content
  always_comb begin
    unique case (op)
      CELL_HOLD:       word_nxt = word_r;
      CELL_FROM_LEFT:  word_nxt = left_word;
      CELL_FROM_RIGHT: word_nxt = right_word;
      CELL_LOAD:       word_nxt = load_word;
      default:         word_nxt = word_r;
    endcase
  end

  // Hold the word
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign cur_word = word_r;
  assign nxt_word = word_nxt;

endmodule

>>> rtl/cad_chain.sv
// ----------------------------------------------------------------------------
// cad_chain
// Row of cells holding the queue in order from one end, that end in cell 0.
// Push and pop shift the whole row by one; append writes at the fill count.
// ----------------------------------------------------------------------------
module cad_chain import cad_pkg::*; #(
  parameter int unsigned CELLS = 7,
  parameter int unsigned CNT_W = 3
) (
  input  logic             clk,
  input  cad_chain_op_t    op,
  input  logic [CNT_W-1:0] count,
  input  cad_word_t        push_word,
  output cad_word_t        head_nxt
);

  cad_word_t    cur_word [CELLS];
  cad_word_t    nxt_word [CELLS];
  cad_word_t    left_word [CELLS];
  cad_word_t    right_word [CELLS];
  cad_cell_op_t cell_op [CELLS];

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    // Wire the neighbors; the request word enters at cell 0
    if (i == 0) begin : g_first
      assign left_word[i] = push_word;
    end else begin : g_inner
      assign left_word[i] = cur_word[i-1];
    end
    if (i == CELLS - 1) begin : g_last
      assign right_word[i] = '0;
    end else begin : g_mid
      assign right_word[i] = cur_word[i+1];
    end

    // Decode the chain operation for this cell
    always_comb begin
      unique case (op)
        CHAIN_HOLD:   cell_op[i] = CELL_HOLD;
        CHAIN_PUSH:   cell_op[i] = CELL_FROM_LEFT;
        CHAIN_POP:    cell_op[i] = CELL_FROM_RIGHT;
        CHAIN_APPEND: cell_op[i] = (count == CNT_W'(i)) ? CELL_LOAD : CELL_HOLD;
        default:      cell_op[i] = CELL_HOLD;
      endcase
    end

    cad_cell u_cell (
      .clk        (clk),
      .op         (cell_op[i]),
      .left_word  (left_word[i]),
      .right_word (right_word[i]),
      .load_word  (push_word),
      .cur_word   (cur_word[i]),
      .nxt_word   (nxt_word[i])
    );
  end

  assign head_nxt = nxt_word[0];

endmodule
